FILE: rtl/letterbox_compositor_with_marker_defines.svh
// Assertion macros shared by the compositor RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef LETTERBOX_COMPOSITOR_WITH_MARKER_DEFINES_SVH
`define LETTERBOX_COMPOSITOR_WITH_MARKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lcm_pkg.sv
// Shared types, register indexes and constants of the letterbox compositor.
// No dependencies.
`default_nettype none
package lcm_pkg;

   localparam int DispWidthDefault  = 1920;
   localparam int DispHeightDefault = 1080;

   // register indexes on the csr channel
   localparam logic [2:0] CsrHOffset   = 3'd0;
   localparam logic [2:0] CsrVOffset   = 3'd1;
   localparam logic [2:0] CsrImgWidth  = 3'd2;
   localparam logic [2:0] CsrImgHeight = 3'd3;
   localparam logic [2:0] CsrColorMode = 3'd4;
   localparam logic [2:0] CsrMarkKind  = 3'd5;
   localparam logic [2:0] CsrMarkX     = 3'd6;
   localparam logic [2:0] CsrMarkY     = 3'd7;

   // marker kinds; the unused code draws nothing
   localparam logic [1:0] MarkNone = 2'd0;
   localparam logic [1:0] MarkRedX = 2'd1;
   localparam logic [1:0] MarkRing = 2'd2;

   localparam logic ModeGray = 1'b0;
   localparam logic ModeRgb  = 1'b1;

   localparam logic [11:0] XHalfLen  = 12'd10;
   localparam logic [12:0] XThick    = 13'd4;
   localparam logic [11:0] RingOuter = 12'd10;
   localparam logic [7:0]  RingMinSq = 8'd49;
   localparam logic [7:0]  RingMaxSq = 8'd100;
   localparam logic [3:0]  ChanFull  = 4'hF;
   localparam logic [3:0]  ChanOff   = 4'h0;

   typedef struct packed {
      logic [10:0] h_offset;
      logic [10:0] v_offset;
      logic [10:0] img_width;
      logic [10:0] img_height;
      logic        color_mode;
      logic [1:0]  marker_kind;
      logic [10:0] marker_x;
      logic [10:0] marker_y;
   } cfg_type;

   typedef struct packed {
      logic [3:0] red;
      logic [3:0] green;
      logic [3:0] blue;
      logic       src_used;
   } pix_type;

   function automatic logic [11:0] abs12(input logic signed [11:0] v);
      abs12 = v[11] ? 12'(-v) : 12'(v);
   endfunction

   function automatic logic [12:0] abs13(input logic signed [12:0] v);
      abs13 = v[12] ? 13'(-v) : 13'(v);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/lcm_csr.sv
// Configuration register file of the compositor, written over the csr channel.
// Depends on lcm_pkg.
`default_nettype none
module lcm_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [10:0]      csr_data,
   output lcm_pkg::cfg_type      cfg
);

   lcm_pkg::cfg_type cfg_ff;
   lcm_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lcm_pkg::CsrHOffset:   cfg_in.h_offset    = csr_data;
            lcm_pkg::CsrVOffset:   cfg_in.v_offset    = csr_data;
            lcm_pkg::CsrImgWidth:  cfg_in.img_width   = csr_data;
            lcm_pkg::CsrImgHeight: cfg_in.img_height  = csr_data;
            lcm_pkg::CsrColorMode: cfg_in.color_mode  = csr_data[0];
            lcm_pkg::CsrMarkKind:  cfg_in.marker_kind = csr_data[1:0];
            lcm_pkg::CsrMarkX:     cfg_in.marker_x    = csr_data;
            lcm_pkg::CsrMarkY:     cfg_in.marker_y    = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.h_offset    <= 11'd640;
         cfg_ff.v_offset    <= 11'd314;
         cfg_ff.img_width   <= 11'd640;
         cfg_ff.img_height  <= 11'd452;
         cfg_ff.color_mode  <= lcm_pkg::ModeRgb;
         cfg_ff.marker_kind <= lcm_pkg::MarkNone;
         cfg_ff.marker_x    <= 11'd0;
         cfg_ff.marker_y    <= 11'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/lcm_pixel.sv
// Per-pixel datapath: window test, source color unpack and marker override.
// Purely combinational; depends on lcm_pkg.
`default_nettype none
module lcm_pixel #(
   parameter int DISPLAY_WIDTH  = lcm_pkg::DispWidthDefault,
   parameter int DISPLAY_HEIGHT = lcm_pkg::DispHeightDefault
) (
   input  wire lcm_pkg::cfg_type cfg,
   input  wire logic [10:0]  pos_x,
   input  wire logic [10:0]  pos_y,
   input  wire logic [23:0]  src_pixel,
   output lcm_pkg::pix_type  pix
);

   localparam logic [12:0] DispW = 13'(DISPLAY_WIDTH);
   localparam logic [12:0] DispH = 13'(DISPLAY_HEIGHT);

   logic [11:0]        h_end;
   logic [11:0]        v_end;
   logic               in_window;
   logic               on_display;
   logic signed [11:0] dx;
   logic signed [11:0] dy;
   logic [11:0]        adx;
   logic [11:0]        ady;
   logic [12:0]        a_diff;
   logic [12:0]        a_sum;
   logic               hit_x;
   logic [7:0]         dx_sq;
   logic [7:0]         dy_sq;
   logic [7:0]         dist_sq;
   logic               near_ring;
   logic               hit_ring;
   logic [3:0]         gray;

   // window ends taken one bit wider so they never wrap
   assign h_end     = {1'b0, cfg.h_offset} + {1'b0, cfg.img_width};
   assign v_end     = {1'b0, cfg.v_offset} + {1'b0, cfg.img_height};
   assign in_window = (pos_x >= cfg.h_offset) && ({1'b0, pos_x} < h_end) &&
                      (pos_y >= cfg.v_offset) && ({1'b0, pos_y} < v_end);

   assign on_display = ({2'b00, pos_x} < DispW) && ({2'b00, pos_y} < DispH);

   assign dx  = $signed({1'b0, pos_x}) - $signed({1'b0, cfg.marker_x});
   assign dy  = $signed({1'b0, pos_y}) - $signed({1'b0, cfg.marker_y});
   assign adx = lcm_pkg::abs12(dx);
   assign ady = lcm_pkg::abs12(dy);

   assign a_diff = lcm_pkg::abs13(13'(13'(dx) - 13'(dy)));
   assign a_sum  = lcm_pkg::abs13(13'(13'(dx) + 13'(dy)));
   assign hit_x  = (ady <= lcm_pkg::XHalfLen) &&
                   ((a_diff <= lcm_pkg::XThick) || (a_sum <= lcm_pkg::XThick));

   // squares only matter once both offsets are within the ring box
   assign near_ring = (adx <= lcm_pkg::RingOuter) && (ady <= lcm_pkg::RingOuter);
   assign dx_sq     = 8'(adx[3:0]) * 8'(adx[3:0]);
   assign dy_sq     = 8'(ady[3:0]) * 8'(ady[3:0]);
   assign dist_sq   = dx_sq + dy_sq;
   assign hit_ring  = near_ring && (dist_sq >= lcm_pkg::RingMinSq) &&
                      (dist_sq <= lcm_pkg::RingMaxSq);

   assign gray = src_pixel[7:4];

   always_comb begin
      pix.src_used = in_window;
      pix.red      = lcm_pkg::ChanOff;
      pix.green    = lcm_pkg::ChanOff;
      pix.blue     = lcm_pkg::ChanOff;
      if (in_window) begin
         if (cfg.color_mode == lcm_pkg::ModeRgb) begin
            pix.red   = src_pixel[23:20];
            pix.green = src_pixel[15:12];
            pix.blue  = src_pixel[7:4];
         end else begin
            pix.red   = gray;
            pix.green = gray;
            pix.blue  = gray;
         end
      end
      if (on_display) begin
         if ((cfg.marker_kind == lcm_pkg::MarkRedX) && hit_x) begin
            pix.red   = lcm_pkg::ChanFull;
            pix.green = lcm_pkg::ChanOff;
            pix.blue  = lcm_pkg::ChanOff;
         end else if ((cfg.marker_kind == lcm_pkg::MarkRing) && hit_ring) begin
            pix.red   = lcm_pkg::ChanOff;
            pix.green = lcm_pkg::ChanFull;
            pix.blue  = lcm_pkg::ChanOff;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/letterbox_compositor_with_marker.sv
// Letterbox compositor with marker overlay: two register stages around lcm_pixel.
// An accepted req word goes into the input register and then into the result register, which drives the rsp word.
// Throughput: one pixel per cycle; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// Reset: synchronous, active high; empties both stages and loads the register
// defaults (640/314 window origin, 640x452 window, RGB mode, no marker).
`default_nettype none
`include "letterbox_compositor_with_marker_defines.svh"
module letterbox_compositor_with_marker #(
   parameter int DISPLAY_WIDTH  = lcm_pkg::DispWidthDefault,
   parameter int DISPLAY_HEIGHT = lcm_pkg::DispHeightDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // pos_x[10:0], pos_y[21:11], src_pixel[45:22]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // red[3:0], green[7:4], blue[11:8]
   output logic             rsp_tuser,   // src_used[0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [10:0] csr_data
);

   lcm_pkg::cfg_type cfg;
   lcm_pkg::pix_type pix;
   lcm_pkg::pix_type rsp_ff;

   logic        in_valid_ff;
   logic [45:0] in_word_ff;
   logic        rsp_valid_ff;
   logic        rsp_load;
   logic        in_load;

   lcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lcm_pixel #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_pixel (
      .cfg       (cfg),
      .pos_x     (in_word_ff[10:0]),
      .pos_y     (in_word_ff[21:11]),
      .src_pixel (in_word_ff[45:22]),
      .pix       (pix)
   );

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign in_load    = !in_valid_ff || rsp_load;
   assign req_tready = in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_tvalid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload: hold unless the stage advances
   always_ff @(posedge clock) begin
      if (in_load && req_tvalid) begin
         in_word_ff <= req_tdata[45:0];
      end
      if (rsp_load && in_valid_ff) begin
         rsp_ff <= pix;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_ff.blue, rsp_ff.green, rsp_ff.red};
   assign rsp_tuser  = rsp_ff.src_used;

   `LCM_ASSERT_NXT(a_req_fills_stage, req_tvalid && req_tready, in_valid_ff,
      "accepted word did not reach the input register")
   `LCM_ASSERT_NXT(a_stage_moves, in_valid_ff && rsp_load, rsp_tvalid,
      "input register word did not reach the result register")
   `LCM_ASSERT_IMP(a_outside_black,
      rsp_tvalid && !rsp_tuser && (cfg.marker_kind == lcm_pkg::MarkNone),
      rsp_tdata == 16'h0000, "pixel outside the window is not black")
   `LCM_ASSERT_IMP(a_gray_equal,
      rsp_tvalid && (cfg.marker_kind == lcm_pkg::MarkNone) &&
      (cfg.color_mode == lcm_pkg::ModeGray),
      (rsp_ff.red == rsp_ff.green) && (rsp_ff.green == rsp_ff.blue),
      "gray pixel has unequal channels")

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for letterbox_compositor_with_marker: drives pixel words
// and register writes, predicts every result word and compares it field by field.
// Depends on rtl/lcm_pkg.sv and the compositor RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int DispW = lcm_pkg::DispWidthDefault;
   localparam int DispH = lcm_pkg::DispHeightDefault;
   localparam logic [1:0] MarkUnused = 2'd3;
   localparam int CrossHalf = 10;
   localparam int CrossThick = 4;
   localparam int RingReach = 10;
   localparam int RingMinD2 = 49;
   localparam int RingMaxD2 = 100;
   localparam int PrintCap = 50;

   // Expected pixel colors, kept in acceptance order.
   class pixel_scoreboard;
      lcm_pkg::cfg_type regs;
      lcm_pkg::pix_type pixel_q[$];
      int unsigned errors;
      int unsigned seen;

      function new();
         regs.h_offset = 11'd640;
         regs.v_offset = 11'd314;
         regs.img_width = 11'd640;
         regs.img_height = 11'd452;
         regs.color_mode = lcm_pkg::ModeRgb;
         regs.marker_kind = lcm_pkg::MarkNone;
         regs.marker_x = 11'd0;
         regs.marker_y = 11'd0;
         errors = 0;
         seen = 0;
      endfunction

      function void write_reg(input logic [2:0] idx, input logic [10:0] val);
         case (idx)
            lcm_pkg::CsrHOffset: regs.h_offset = val;
            lcm_pkg::CsrVOffset: regs.v_offset = val;
            lcm_pkg::CsrImgWidth: regs.img_width = val;
            lcm_pkg::CsrImgHeight: regs.img_height = val;
            lcm_pkg::CsrColorMode: regs.color_mode = val[0];
            lcm_pkg::CsrMarkKind: regs.marker_kind = val[1:0];
            lcm_pkg::CsrMarkX: regs.marker_x = val;
            lcm_pkg::CsrMarkY: regs.marker_y = val;
            default: ;
         endcase
      endfunction

      function int mag(input int v);
         return (v < 0) ? -v : v;
      endfunction

      function lcm_pkg::pix_type composite(input logic [10:0] px, input logic [10:0] py,
                                           input logic [23:0] src);
         lcm_pkg::pix_type p;
         int dx, dy, d2;
         bit on_cross, on_ring;
         p = '0;
         if (int'(py) >= int'(regs.v_offset) &&
             int'(py) < int'(regs.v_offset) + int'(regs.img_height) &&
             int'(px) >= int'(regs.h_offset) &&
             int'(px) < int'(regs.h_offset) + int'(regs.img_width)) begin
            p.src_used = 1'b1;
            if (regs.color_mode == lcm_pkg::ModeRgb) begin
               p.red = src[23:20];
               p.green = src[15:12];
               p.blue = src[7:4];
            end else begin
               p.red = src[7:4];
               p.green = src[7:4];
               p.blue = src[7:4];
            end
         end
         // the marker never reaches past the visible display
         if (int'(px) < DispW && int'(py) < DispH) begin
            dx = int'(px) - int'(regs.marker_x);
            dy = int'(py) - int'(regs.marker_y);
            on_cross = mag(dy) <= CrossHalf &&
                       (mag(dx - dy) <= CrossThick || mag(dx + dy) <= CrossThick);
            on_ring = 1'b0;
            if (mag(dx) <= RingReach && mag(dy) <= RingReach) begin
               d2 = dx * dx + dy * dy;
               on_ring = d2 >= RingMinD2 && d2 <= RingMaxD2;
            end
            if (regs.marker_kind == lcm_pkg::MarkRedX && on_cross) begin
               p.red = lcm_pkg::ChanFull;
               p.green = lcm_pkg::ChanOff;
               p.blue = lcm_pkg::ChanOff;
            end else if (regs.marker_kind == lcm_pkg::MarkRing && on_ring) begin
               p.red = lcm_pkg::ChanOff;
               p.green = lcm_pkg::ChanFull;
               p.blue = lcm_pkg::ChanOff;
            end
         end
         return p;
      endfunction

      function void note(input logic [10:0] px, input logic [10:0] py,
                         input logic [23:0] src);
         pixel_q.push_back(composite(px, py, src));
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= PrintCap) $display("mismatch at word %0d: %s", seen, msg);
      endtask

      task check(input logic [15:0] data, input logic used);
         lcm_pkg::pix_type want;
         if (pixel_q.size() == 0) begin
            report("result word with no pixel waiting");
            return;
         end
         want = pixel_q.pop_front();
         if (data[3:0] !== want.red)
            report($sformatf("red %0h, want %0h", data[3:0], want.red));
         if (data[7:4] !== want.green)
            report($sformatf("green %0h, want %0h", data[7:4], want.green));
         if (data[11:8] !== want.blue)
            report($sformatf("blue %0h, want %0h", data[11:8], want.blue));
         if (used !== want.src_used)
            report($sformatf("src_used %0b, want %0b", used, want.src_used));
         seen++;
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [47:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [15:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [10:0] csr_data;

   pixel_scoreboard sb = new();
   bit calm;
   int hold_left;
   int stall_left;

   letterbox_compositor_with_marker dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser);
   end

   // Receiver: a long hold-off when asked, otherwise random stall bursts.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

   function automatic lcm_pkg::cfg_type make_settings(input int h, input int v, input int w,
                                                      input int ht, input logic mode,
                                                      input logic [1:0] kind,
                                                      input int mx, input int my);
      lcm_pkg::cfg_type c;
      c.h_offset = 11'(h);
      c.v_offset = 11'(v);
      c.img_width = 11'(w);
      c.img_height = 11'(ht);
      c.color_mode = mode;
      c.marker_kind = kind;
      c.marker_x = 11'(mx);
      c.marker_y = 11'(my);
      return c;
   endfunction

   function automatic int pick_len(input int top);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 1;
         2: return top;
         default: return $urandom_range(1, top);
      endcase
   endfunction

   function automatic lcm_pkg::cfg_type random_settings();
      return make_settings($urandom_range(0, 1919), $urandom_range(0, 1079),
                           pick_len(1920), pick_len(1080), 1'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)), $urandom_range(0, 1919),
                           $urandom_range(0, 1079));
   endfunction

   // Bias one coordinate toward window edges, display edges and the marker.
   function automatic logic [10:0] pick_coord(input int lo, input int len,
                                              input int mark, input int disp);
      int v;
      case ($urandom_range(0, 5))
         0: v = lo + $urandom_range(0, 4) - 2;
         1: v = lo + len + $urandom_range(0, 4) - 3;
         2: v = disp + $urandom_range(0, 3) - 2;
         3: v = mark + $urandom_range(0, 26) - 13;
         default: v = $urandom_range(0, 2047);
      endcase
      return 11'(v);
   endfunction

   task automatic send_pixel(input logic [10:0] px, input logic [10:0] py,
                             input logic [23:0] src);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, src, py, px};
      do @(posedge clock); while (!req_tready);
      sb.note(px, py, src);
   endtask

   task automatic sender_gap(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic csr_word(input logic [2:0] idx, input logic [10:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic apply_settings(input lcm_pkg::cfg_type c);
      csr_word(lcm_pkg::CsrHOffset, c.h_offset);
      csr_word(lcm_pkg::CsrVOffset, c.v_offset);
      csr_word(lcm_pkg::CsrImgWidth, c.img_width);
      csr_word(lcm_pkg::CsrImgHeight, c.img_height);
      csr_word(lcm_pkg::CsrColorMode, {10'd0, c.color_mode});
      csr_word(lcm_pkg::CsrMarkKind, {9'd0, c.marker_kind});
      csr_word(lcm_pkg::CsrMarkX, c.marker_x);
      csr_word(lcm_pkg::CsrMarkY, c.marker_y);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every expected pixel, then let the pipeline settle.
   task automatic drain();
      sender_gap(1);
      while (sb.pixel_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int count, input bit with_hold, input bit with_pause);
      logic [10:0] px, py;
      for (int i = 0; i < count; i++) begin
         if (!calm && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 15));
         if ($urandom_range(0, 9) < 4) begin
            px = 11'(int'(sb.regs.marker_x) + $urandom_range(0, 24) - 12);
            py = 11'(int'(sb.regs.marker_y) + $urandom_range(0, 24) - 12);
         end else begin
            px = pick_coord(int'(sb.regs.h_offset), int'(sb.regs.img_width),
                            int'(sb.regs.marker_x), DispW);
            py = pick_coord(int'(sb.regs.v_offset), int'(sb.regs.img_height),
                            int'(sb.regs.marker_y), DispH);
         end
         send_pixel(px, py, 24'($urandom()));
         // starve the output so both stages fill and the input stalls
         if (with_hold && i == 10) hold_left = 80;
         if (with_pause && i == count / 2) drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = lcm_pkg::CsrHOffset;
      csr_data = '0;
      calm = 1'b0;
      hold_left = 0;
      stall_left = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // reset defaults: window corners, origin, top of the coordinate range
      send_pixel(11'd640, 11'd314, 24'hFFFFFF);
      send_pixel(11'd639, 11'd314, 24'hFFFFFF);
      send_pixel(11'd1279, 11'd765, 24'hA5C3F0);
      send_pixel(11'd1280, 11'd765, 24'hA5C3F0);
      send_pixel(11'd0, 11'd0, 24'h000000);
      send_pixel(11'd2047, 11'd2047, 24'hFFFFFF);

      // red X over a full-display gray window: arm ends and thickness edges
      drain();
      apply_settings(make_settings(0, 0, 1920, 1080, lcm_pkg::ModeGray, lcm_pkg::MarkRedX,
                                   20, 20));
      send_pixel(11'd20, 11'd20, 24'h0000F0);
      send_pixel(11'd30, 11'd30, 24'h00007F);
      send_pixel(11'd31, 11'd31, 24'h00007F);
      send_pixel(11'd24, 11'd20, 24'h123456);
      send_pixel(11'd25, 11'd20, 24'h123456);
      send_pixel(11'd10, 11'd30, 24'hFFFF0F);

      // ring at the display corner: radius limits and a pixel past the display
      drain();
      apply_settings(make_settings(1900, 1060, 19, 19, lcm_pkg::ModeRgb, lcm_pkg::MarkRing,
                                   1915, 1075));
      send_pixel(11'd1922, 11'd1075, 24'h808080);
      send_pixel(11'd1908, 11'd1075, 24'h808080);
      send_pixel(11'd1905, 11'd1075, 24'h808080);
      send_pixel(11'd1904, 11'd1075, 24'h808080);
      send_pixel(11'd1911, 11'd1071, 24'h808080);
      send_pixel(11'd1915, 11'd1068, 24'h808080);

      // unused marker kind over an empty window
      drain();
      apply_settings(make_settings(100, 100, 0, 5, lcm_pkg::ModeRgb, MarkUnused, 100, 100));
      send_pixel(11'd100, 11'd100, 24'hFFFFFF);
      send_pixel(11'd101, 11'd101, 24'hFFFFFF);

      drain();
      apply_settings(make_settings(1919, 1079, 1920, 1080, lcm_pkg::ModeRgb,
                                   lcm_pkg::MarkRing, 0, 0));
      run_random(150, 1'b0, 1'b0);
      drain();
      apply_settings(make_settings(0, 0, 0, 0, lcm_pkg::ModeGray, lcm_pkg::MarkRedX,
                                   1919, 1079));
      run_random(150, 1'b0, 1'b0);
      drain();
      apply_settings(make_settings(0, 0, 1920, 1080, lcm_pkg::ModeGray, lcm_pkg::MarkRing,
                                   1919, 0));
      run_random(150, 1'b0, 1'b0);
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         apply_settings(random_settings());
         run_random(150, ph == 0, ph == 1);
      end
      drain();
      calm = 1'b1;
      apply_settings(random_settings());
      run_random(150, 1'b0, 1'b0);

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
